// ===== hw/rtl/phq_pkg.sv =====
// Shared constants, payload types and the entry ordering for the priority heap queue.
`timescale 1ns / 1ps

package phq_pkg;

  localparam int CAPACITY = 64;
  localparam int TAG_BITS = 16;
  localparam int PRIO_W   = 4;
  localparam int SEQ_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 1;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [PRIO_W-1:0] entry_priority;
    logic [TAG_BITS-1:0]      entry_tag;
  } phq_req_t;

  typedef struct packed {
    logic                     top_valid;
    logic signed [PRIO_W-1:0] top_priority;
    logic [TAG_BITS-1:0]      top_tag;
    logic [CNT_W-1:0]         entry_count;
    logic [1:0]               status;
  } phq_rsp_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
    logic [SEQ_W-1:0]         seq;
  } heap_ent_t;

  localparam int ENT_W = $bits(heap_ent_t);

  // Higher priority wins; on equal priority the larger sequence number wins.
  function automatic logic outranks(heap_ent_t p, heap_ent_t q);
    if (p.prio != q.prio) begin
      return $signed(p.prio) > $signed(q.prio);
    end
    return p.seq > q.seq;
  endfunction

endpackage

// ===== hw/rtl/phq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module phq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== hw/rtl/priority_heap_queue.sv =====
// Top level of the priority heap queue: command handshake, sift sequencer and heap RAM.
`timescale 1ns / 1ps

// A bounded max-priority queue held as a binary heap in one RAM. Raise start
// with a command on req_i; it transfers at the edge where start is high and
// busy is low. Its result (top entry before the command, count after it,
// status) appears on rsp_o with done_o high for exactly one cycle, the cycle
// right after the transfer, and cannot be held off. A query, a dropped insert,
// a remove on empty and a remove of the last entry leave busy low, so the next
// command may transfer in the very next cycle. An insert keeps busy high while the
// new entry climbs: at each level it reads the parent, compares, and either pulls
// the parent down into the hole and climbs on or writes the entry and stops; at
// the root it writes the entry with no read. A remove keeps busy high while it
// takes in the fetched last entry and sinks it: at each level it reads and compares
// the left child, then the right child if there is one, and lifts the winning
// child and descends, or writes the entry and stops, as at a slot without children.
// These steps follow from the single read port of the heap RAM and its registered
// read data: each parent or child compare waits for one read. Ties go to the
// newest entry by a 32-bit arrival number that wraps.
// There is no clearing pass: entries at or above the count are never read.

module priority_heap_queue
  import phq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  phq_req_t req_i,
  output logic     done_o,
  output phq_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_FETCH,
    S_DN_L,
    S_DN_LCMP,
    S_DN_RCMP
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SEQ_W-1:0]    seq_q, seq_d;
  logic [ADDR_W-1:0]   pos_q, pos_d;
  heap_ent_t           ent_q, ent_d;      // entry being sifted
  heap_ent_t           best_q, best_d;    // winner after the left compare
  logic                bchild_q, bchild_d;
  logic [ADDR_W-1:0]   bidx_q, bidx_d;
  heap_ent_t           top_q, top_d;      // shadow of heap slot zero
  phq_rsp_t            rsp_q, rsp_d;
  logic                done_q, done_d;

  // RAM port
  logic                wr_en, rd_en;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  heap_ent_t           wr_data;
  logic [ENT_W-1:0]    rd_raw;
  heap_ent_t           rd_ent;

  // Index arithmetic
  logic [ADDR_W-1:0]   par_idx;
  logic [IDX_W-1:0]    l_idx, r_idx, n_ext;

  // Shared resolve step of sift-down
  logic                res_go, res_child;
  heap_ent_t           res_ent;
  logic [ADDR_W-1:0]   res_idx;

  logic                accept;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign rd_ent  = heap_ent_t'(rd_raw);
  assign par_idx = (pos_q - 1'b1) >> 1;
  assign l_idx   = {pos_q, 1'b1};
  assign r_idx   = l_idx + IDX_W'(1);
  assign n_ext   = IDX_W'(cnt_q);

  phq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    seq_d    = seq_q;
    pos_d    = pos_q;
    ent_d    = ent_q;
    best_d   = best_q;
    bchild_d = bchild_q;
    bidx_d   = bidx_q;
    rsp_d    = rsp_q;
    done_d   = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = ent_q;
    rd_en    = 1'b0;
    rd_addr  = pos_q;
    res_go    = 1'b0;
    res_child = 1'b0;
    res_ent   = ent_q;
    res_idx   = pos_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          // Report the top as it stands before this command.
          done_d             = 1'b1;
          rsp_d.top_valid    = (cnt_q != '0);
          rsp_d.top_priority = (cnt_q != '0) ? top_q.prio : '0;
          rsp_d.top_tag      = (cnt_q != '0) ? top_q.tag : '0;
          rsp_d.status       = ST_OK;
          rsp_d.entry_count  = cnt_q;
          if (req_i.mode == MODE_INSERT) begin
            if (cnt_q >= CNT_W'(CAPACITY)) begin
              rsp_d.status = ST_FULL;
            end else begin
              // Stamp the new entry and start the climb from the first free slot.
              seq_d             = seq_q + 1'b1;
              ent_d.prio        = req_i.entry_priority;
              ent_d.tag         = req_i.entry_tag;
              ent_d.seq         = seq_q + 1'b1;
              pos_d             = cnt_q[ADDR_W-1:0];
              cnt_d             = cnt_q + 1'b1;
              rsp_d.entry_count = cnt_q + 1'b1;
              state_d           = S_UP_RD;
            end
          end else if (req_i.mode == MODE_REMOVE) begin
            if (cnt_q == '0) begin
              rsp_d.status = ST_EMPTY;
            end else begin
              cnt_d             = cnt_q - 1'b1;
              rsp_d.entry_count = cnt_q - 1'b1;
              if (cnt_q != CNT_W'(1)) begin
                // Fetch the last entry; it refills the root and sinks.
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(cnt_q - 1'b1);
                state_d = S_DN_FETCH;
              end
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = par_idx;
          state_d = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        wr_en = 1'b1;
        if (outranks(ent_q, rd_ent)) begin
          // Pull the parent down into the hole and climb.
          wr_data = rd_ent;
          pos_d   = par_idx;
          state_d = S_UP_RD;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_DN_FETCH: begin
        ent_d   = rd_ent;
        pos_d   = '0;
        state_d = S_DN_L;
      end

      S_DN_L: begin
        if (l_idx >= n_ext) begin
          wr_en   = 1'b1;
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = l_idx[ADDR_W-1:0];
          state_d = S_DN_LCMP;
        end
      end

      S_DN_LCMP: begin
        if (outranks(rd_ent, ent_q)) begin
          res_ent   = rd_ent;
          res_child = 1'b1;
          res_idx   = l_idx[ADDR_W-1:0];
        end
        if (r_idx < n_ext) begin
          best_d   = res_ent;
          bchild_d = res_child;
          bidx_d   = res_idx;
          rd_en    = 1'b1;
          rd_addr  = r_idx[ADDR_W-1:0];
          state_d  = S_DN_RCMP;
        end else begin
          res_go = 1'b1;
        end
      end

      S_DN_RCMP: begin
        res_go = 1'b1;
        if (outranks(rd_ent, best_q)) begin
          res_ent   = rd_ent;
          res_child = 1'b1;
          res_idx   = r_idx[ADDR_W-1:0];
        end else begin
          res_ent   = best_q;
          res_child = bchild_q;
          res_idx   = bidx_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Settle one sift-down level: stop, or lift the winning child and descend.
    if (res_go) begin
      wr_en = 1'b1;
      if (res_child) begin
        wr_data = res_ent;
        pos_d   = res_idx;
        state_d = S_DN_L;
      end else begin
        state_d = S_IDLE;
      end
    end
  end

  // Keep the root copy in step with every write to slot zero.
  assign top_d = (wr_en && (wr_addr == '0)) ? wr_data : top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      seq_q    <= '0;
      pos_q    <= '0;
      ent_q    <= '0;
      best_q   <= '0;
      bchild_q <= 1'b0;
      bidx_q   <= '0;
      top_q    <= '0;
      rsp_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      seq_q    <= seq_d;
      pos_q    <= pos_d;
      ent_q    <= ent_d;
      best_q   <= best_d;
      bchild_q <= bchild_d;
      bidx_q   <= bidx_d;
      top_q    <= top_d;
      rsp_q    <= rsp_d;
      done_q   <= done_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result appears only in the cycle after a command transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result strobe without a preceding transfer");

  // The count never exceeds the heap depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // An accepted insert into a non-full heap advances the arrival number by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.mode == MODE_INSERT) && (cnt_q < CNT_W'(CAPACITY)))
      |=> (seq_q == $past(seq_q) + 1'b1))
    else $error("arrival number did not advance on insert");

  // The heap RAM is never written while the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !wr_en)
    else $error("heap write while idle");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the priority heap queue: directed, fill/drain and random traffic.
`timescale 1ns / 1ps

module testbench
  import phq_pkg::*;
();

  // Mode 3 has no name in the package; the block treats it as a query.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 32;

  // Predictor entry: priority, tag and the arrival number used to break ties.
  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_BITS-1:0]      tag;
    logic [SEQ_W-1:0]         seq;
  } slot_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  phq_req_t req_i;
  logic     done_o;
  phq_rsp_t rsp_o;

  // Predictor state: a heap kept the same way as the block keeps it.
  slot_t           mdl_heap [CAPACITY];
  int              mdl_count;
  logic [SEQ_W-1:0] mdl_seq;

  // Results predicted at each transfer, oldest first.
  phq_rsp_t pending_rsp [$];

  int  err_count;
  int  xfer_count;
  int  idle_cycles;
  bit  idle_on;
  int  n_insert, n_full, n_remove, n_empty, n_query, peak_count;

  priority_heap_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Higher priority wins; equal priority goes to the larger arrival number.
  function automatic bit ranks_above(slot_t a, slot_t b);
    if (a.prio != b.prio) begin
      return $signed(a.prio) > $signed(b.prio);
    end
    return a.seq > b.seq;
  endfunction

  // Apply one command to the predictor heap and return the result it must produce.
  function automatic phq_rsp_t heap_apply(phq_req_t cmd);
    phq_rsp_t r;
    slot_t    tmp;
    int       pos;
    int       up;
    int       best;
    int       lc;
    int       rc;
    r = '0;
    r.status = ST_OK;
    // Report the top as it stands before the command; zeros when empty.
    if (mdl_count > 0) begin
      r.top_valid    = 1'b1;
      r.top_priority = mdl_heap[0].prio;
      r.top_tag      = mdl_heap[0].tag;
    end
    case (cmd.mode)
      MODE_INSERT: begin
        n_insert++;
        if (mdl_count >= CAPACITY) begin
          // Drop the entry; the arrival counter holds.
          r.status = ST_FULL;
          n_full++;
        end else begin
          mdl_seq = mdl_seq + 1'b1;
          pos = mdl_count;
          mdl_heap[pos] = '{cmd.entry_priority, cmd.entry_tag, mdl_seq};
          // Climb while the new entry outranks its parent.
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!ranks_above(mdl_heap[pos], mdl_heap[up])) break;
            tmp = mdl_heap[pos];
            mdl_heap[pos] = mdl_heap[up];
            mdl_heap[up] = tmp;
            pos = up;
          end
          mdl_count++;
        end
      end
      MODE_REMOVE: begin
        n_remove++;
        if (mdl_count == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          // Move the last entry to the root and sink it.
          mdl_count--;
          mdl_heap[0] = mdl_heap[mdl_count];
          pos = 0;
          while (pos < mdl_count) begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < mdl_count && ranks_above(mdl_heap[lc], mdl_heap[best])) best = lc;
            if (rc < mdl_count && ranks_above(mdl_heap[rc], mdl_heap[best])) best = rc;
            if (best == pos) break;
            tmp = mdl_heap[pos];
            mdl_heap[pos] = mdl_heap[best];
            mdl_heap[best] = tmp;
            pos = best;
          end
        end
      end
      default: begin
        n_query++;
      end
    endcase
    if (mdl_count > peak_count) peak_count = mdl_count;
    r.entry_count = CNT_W'(mdl_count);
    return r;
  endfunction

  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      err_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, name, expv, actv);
    end
  endtask

  // Compare each result with the oldest prediction, then log any new transfer.
  // Sample at the rising edge, before the block's registers update.
  always @(posedge clk_i) begin
    phq_rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp.size() == 0) begin
          err_count++;
          $display("%0t ns: result with nothing expected, expected none, got %h",
                   $realtime, rsp_o);
        end else begin
          want = pending_rsp.pop_front();
          check_field("top_valid",    want.top_valid,             rsp_o.top_valid);
          check_field("top_priority", $signed(want.top_priority), $signed(rsp_o.top_priority));
          check_field("top_tag",      want.top_tag,               rsp_o.top_tag);
          check_field("entry_count",  want.entry_count,           rsp_o.entry_count);
          check_field("status",       want.status,                rsp_o.status);
        end
      end
      if (start && !busy) begin
        pending_rsp.push_back(heap_apply(req_i));
        xfer_count++;
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        // Stop a hung run: nothing has transferred for far too long.
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  // Send one command: idle for a while at random, then hold start until it transfers.
  task automatic send_cmd(input logic [1:0] mode, input logic [PRIO_W-1:0] prio,
                          input logic [TAG_BITS-1:0] tag);
    int gap;
    bit taken;
    gap = 0;
    if (idle_on && $urandom_range(99) < 36) begin
      // Mostly short gaps; some long enough to cover a whole sift.
      gap = ($urandom_range(3) == 0) ? $urandom_range(22, 4) : $urandom_range(3, 1);
    end
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
      req_i = $bits(phq_req_t)'($urandom);
    end
    @(negedge clk_i);
    start = 1'b1;
    req_i.mode = mode;
    req_i.entry_priority = prio;
    req_i.entry_tag = tag;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
  endtask

  // Draw one random command; priorities mostly from -1 to 4, tags often at the ends.
  task automatic send_random(input int ins_pct, input int rem_pct);
    int                  pick;
    logic [1:0]          mode;
    logic [PRIO_W-1:0]   prio;
    logic [TAG_BITS-1:0] tag;
    pick = $urandom_range(99);
    if (pick < ins_pct) mode = MODE_INSERT;
    else if (pick < ins_pct + rem_pct) mode = MODE_REMOVE;
    else if (pick < 96) mode = MODE_QUERY;
    else mode = MODE_SPARE;
    if ($urandom_range(99) < 85) prio = PRIO_W'($urandom_range(5) - 1);
    else prio = PRIO_W'($urandom_range(15));
    case ($urandom_range(9))
      0:       tag = '0;
      1:       tag = '1;
      default: tag = TAG_BITS'($urandom);
    endcase
    send_cmd(mode, prio, tag);
  endtask

  // Empty-queue cases, priority extremes, ties, the spare mode and a full drain.
  task automatic test_directed();
    send_cmd(MODE_QUERY,  4'sd0, 16'h0000);
    send_cmd(MODE_REMOVE, 4'sd0, 16'hFFFF);
    send_cmd(MODE_SPARE,  4'sd3, 16'h1111);
    send_cmd(MODE_INSERT, -4'sd1, 16'h0000);
    send_cmd(MODE_INSERT, 4'sd4, 16'hFFFF);
    // Same priority again: the newer entry must take the top.
    send_cmd(MODE_INSERT, 4'sd4, 16'h1234);
    send_cmd(MODE_INSERT, 4'sd7, 16'hAAAA);
    send_cmd(MODE_INSERT, -4'sd8, 16'h5555);
    send_cmd(MODE_INSERT, 4'sd0, 16'h0001);
    send_cmd(MODE_QUERY,  4'sd7, 16'hFFFF);
    send_cmd(MODE_SPARE,  -4'sd8, 16'h0000);
    repeat (6) send_cmd(MODE_REMOVE, 4'sd0, 16'h0000);
    send_cmd(MODE_REMOVE, 4'sd0, 16'h0000);
    send_cmd(MODE_QUERY,  4'sd0, 16'h0000);
  endtask

  // Push past capacity so inserts get dropped, then drain past empty.
  task automatic test_fill_drain();
    repeat (CAPACITY + 4) send_random(100, 0);
    repeat (2) send_cmd(MODE_QUERY, 4'sd0, 16'h0000);
    repeat (CAPACITY + 3) send_cmd(MODE_REMOVE, 4'sd0, 16'h0000);
  endtask

  // Random mix in blocks that lean toward filling, draining or neither.
  task automatic test_random_mix(input int blocks);
    int lean;
    repeat (blocks) begin
      lean = $urandom_range(2);
      repeat (100) begin
        case (lean)
          0:       send_random(70, 22);
          1:       send_random(45, 40);
          default: send_random(25, 65);
        endcase
      end
    end
  endtask

  // Back-to-back commands: the bench adds no idle gaps between them.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (360) send_random(55, 38);
    idle_on = 1'b1;
  endtask

  initial begin
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    mdl_count = 0;
    mdl_seq = '0;
    err_count = 0;
    xfer_count = 0;
    idle_cycles = 0;
    idle_on = 1'b1;
    n_insert = 0;
    n_full = 0;
    n_remove = 0;
    n_empty = 0;
    n_query = 0;
    peak_count = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_fill_drain();
    test_random_mix(10);
    test_back_to_back();
    test_fill_drain();

    // Release start, let every result come back, then allow the tail of a sift.
    @(negedge clk_i);
    start = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands: %0d inserts (%0d dropped when full), %0d removes",
             xfer_count, n_insert, n_full, n_remove);
    $display("(%0d on an empty queue), %0d queries; occupancy peaked at %0d of %0d.",
             n_empty, n_query, peak_count, CAPACITY);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
